FILE: rtl/pcios_pkg.sv
`default_nettype none
package pcios_pkg;

  localparam int NumChunksDef = 4096;
  localparam int CfgW = 11;
  localparam int LbaW = 48;
  localparam int LenW = 24;
  localparam int CntW = 32;
  localparam int TotSecW = 64;
  localparam int ChkSecW = 48;
  localparam int IdxOutW = 12;
  localparam int WinW = 13;
  localparam int SecPerMbLog2 = 11;

  typedef struct packed {
    logic [LbaW-1:0] start_sector;
    logic [LenW-1:0] length_sectors;
    logic            is_write;
  } in_beat_t;

  typedef struct packed {
    logic [IdxOutW-1:0] chunk_index;
    logic               out_of_range;
    logic               first_in_window;
    logic [WinW-1:0]    chunks_in_window;
    logic [CntW-1:0]    total_requests;
    logic [CntW-1:0]    chunk_requests;
  } out_beat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_WRITE
  } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/pcios_front.sv
`default_nettype none
module pcios_front #(
  parameter int NUM_CHUNKS = pcios_pkg::NumChunksDef,
  parameter int IDX_W = $clog2(NUM_CHUNKS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pcios_pkg::in_beat_t          in_data,
  input  wire logic [pcios_pkg::CfgW-1:0]   size_mb,
  output logic                              q_push,
  input  wire logic                         q_full,
  output logic [pcios_pkg::LenW-1:0]        q_len,
  output logic                              q_wr,
  output logic                              q_oor,
  output logic [IDX_W-1:0]                  q_idx
);
  import pcios_pkg::*;

  localparam int DivW = CfgW + SecPerMbLog2;
  localparam int CntBitsW = $clog2(LbaW + 1);

  front_state_t          state_r, state_nxt;
  logic [LbaW-1:0]       quo_r, quo_nxt;
  logic [DivW-1:0]       rem_r, rem_nxt;
  logic [DivW-1:0]       dvs_r, dvs_nxt;
  logic [CntBitsW-1:0]   cnt_r, cnt_nxt;
  logic [LenW-1:0]       len_r, len_nxt;
  logic                  wr_r, wr_nxt;
  logic [DivW:0]         trial;
  logic [DivW:0]         diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    len_r <= len_nxt;
    wr_r  <= wr_nxt;
  end

  assign trial = {rem_r, quo_r[LbaW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    wr_nxt    = wr_r;
    busy      = 1'b1;
    q_push    = 1'b0;
    case (state_r)
      FR_IDLE: begin
        busy = 1'b0;
        if (start) begin
          quo_nxt   = in_data.start_sector;
          rem_nxt   = '0;
          dvs_nxt   = {(size_mb == '0) ? CfgW'(1) : size_mb, {SecPerMbLog2{1'b0}}};
          cnt_nxt   = CntBitsW'(LbaW);
          len_nxt   = in_data.length_sectors;
          wr_nxt    = in_data.is_write;
          state_nxt = FR_DIV;
        end
      end
      FR_DIV: begin
        if (!diff[DivW]) begin
          rem_nxt = diff[DivW-1:0];
          quo_nxt = {quo_r[LbaW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DivW-1:0];
          quo_nxt = {quo_r[LbaW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CntBitsW'(1);
        if (cnt_r == CntBitsW'(1)) state_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  assign q_len = len_r;
  assign q_wr  = wr_r;
  assign q_oor = (quo_r >= LbaW'(NUM_CHUNKS));
  assign q_idx = quo_r[IDX_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/pcios_queue.sv
`default_nettype none
module pcios_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wdata;
  end

  assign full  = cnt_r[1];
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];
endmodule
`default_nettype wire

FILE: rtl/pcios_back.sv
`default_nettype none
module pcios_back #(
  parameter int NUM_CHUNKS = pcios_pkg::NumChunksDef,
  parameter int IDX_W = $clog2(NUM_CHUNKS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  output logic                          q_pop,
  input  wire logic [pcios_pkg::LenW-1:0] q_len,
  input  wire logic                     q_wr,
  input  wire logic                     q_oor,
  input  wire logic [IDX_W-1:0]         q_idx,
  output logic                          out_valid,
  output pcios_pkg::out_beat_t          out_data
);
  import pcios_pkg::*;

  localparam int RowW = 3 * CntW + 3 * ChkSecW + 1;

  typedef struct packed {
    logic [CntW-1:0]    c_all;
    logic [CntW-1:0]    c_rd;
    logic [CntW-1:0]    c_wr;
    logic [ChkSecW-1:0] s_all;
    logic [ChkSecW-1:0] s_rd;
    logic [ChkSecW-1:0] s_wr;
    logic               acc;
  } row_t;

  logic [RowW-1:0] mem [NUM_CHUNKS];
  logic [RowW-1:0] rd_r;

  back_state_t        state_r, state_nxt;
  logic [IDX_W:0]     clr_r, clr_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [LenW-1:0]    len_r, len_nxt;
  logic               wr_r, wr_nxt, oor_r, oor_nxt;
  logic [CntW-1:0]    tc_all_r, tc_rd_r, tc_wr_r;
  logic [TotSecW-1:0] ts_all_r, ts_rd_r, ts_wr_r;
  logic [WinW-1:0]    win_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [RowW-1:0]    wdata;
  row_t               cur, upd;
  logic               do_upd;

  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
    inc_sat = (&v) ? v : v + CntW'(1);
  endfunction

  function automatic logic [ChkSecW-1:0] add48(input logic [ChkSecW-1:0] v,
                                               input logic [LenW-1:0] a);
    logic [ChkSecW:0] s;
    s = {1'b0, v} + (ChkSecW+1)'(a);
    add48 = s[ChkSecW] ? '1 : s[ChkSecW-1:0];
  endfunction

  function automatic logic [TotSecW-1:0] add64(input logic [TotSecW-1:0] v,
                                               input logic [LenW-1:0] a);
    logic [TotSecW:0] s;
    s = {1'b0, v} + (TotSecW+1)'(a);
    add64 = s[TotSecW] ? '1 : s[TotSecW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[idx_r];
  end

  assign cur = row_t'(rd_r);

  always_comb begin
    upd = cur;
    upd.c_all = inc_sat(cur.c_all);
    upd.s_all = add48(cur.s_all, len_r);
    if (wr_r) begin
      upd.c_wr = inc_sat(cur.c_wr);
      upd.s_wr = add48(cur.s_wr, len_r);
    end else begin
      upd.c_rd = inc_sat(cur.c_rd);
      upd.s_rd = add48(cur.s_rd, len_r);
    end
    upd.acc = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      tc_all_r    <= '0;
      tc_rd_r     <= '0;
      tc_wr_r     <= '0;
      ts_all_r    <= '0;
      ts_rd_r     <= '0;
      ts_wr_r     <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= do_upd;
      if (do_upd) begin
        tc_all_r <= inc_sat(tc_all_r);
        ts_all_r <= add64(ts_all_r, len_r);
        if (wr_r) begin
          tc_wr_r <= inc_sat(tc_wr_r);
          ts_wr_r <= add64(ts_wr_r, len_r);
        end else begin
          tc_rd_r <= inc_sat(tc_rd_r);
          ts_rd_r <= add64(ts_rd_r, len_r);
        end
        if (!oor_r && !cur.acc && !(&win_r)) win_r <= win_r + WinW'(1);
      end
    end
    idx_r <= idx_nxt;
    len_r <= len_nxt;
    wr_r  <= wr_nxt;
    oor_r <= oor_nxt;
    if (do_upd) begin
      out_r.chunk_index      <= oor_r ? '0 : IdxOutW'(idx_r);
      out_r.out_of_range     <= oor_r;
      out_r.first_in_window  <= !oor_r && !cur.acc;
      out_r.chunks_in_window <= (!oor_r && !cur.acc && !(&win_r)) ?
                                win_r + WinW'(1) : win_r;
      out_r.total_requests   <= inc_sat(tc_all_r);
      out_r.chunk_requests   <= oor_r ? '0 : upd.c_all;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    wr_nxt    = wr_r;
    oor_nxt   = oor_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = RowW'(upd);
    do_upd    = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r[IDX_W-1:0];
        wdata   = '0;
        clr_nxt = clr_r + (IDX_W+1)'(1);
        if (clr_r == (IDX_W+1)'(NUM_CHUNKS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          idx_nxt   = q_idx;
          len_nxt   = q_len;
          wr_nxt    = q_wr;
          oor_nxt   = q_oor;
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: state_nxt = BK_WRITE;
      BK_WRITE: begin
        do_upd    = 1'b1;
        we        = !oor_r;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

FILE: rtl/per_chunk_io_statistics.sv
`default_nettype none
// Per-chunk I/O statistics. One request is taken when start is high and busy
// low; busy then stays high for 48 steps of a restoring divider that finds
// the chunk index and for the push that follows, longer while the two-entry
// queue is full. The request waits in that queue for a read-modify-write of
// the chunk table. Each request gives one result beat, shown for one cycle
// with out_valid; the receiver cannot stall. After reset the chunk table is
// cleared one row a cycle; requests may be taken meanwhile and queue up
// behind the clearing pass. Write cfg_chunk_size_mb only while idle.
module per_chunk_io_statistics #(
  parameter int NUM_CHUNKS = pcios_pkg::NumChunksDef
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire pcios_pkg::in_beat_t        in_data,
  output logic                            out_valid,
  output pcios_pkg::out_beat_t            out_data,
  input  wire logic                       cfg_we,
  input  wire logic [pcios_pkg::CfgW-1:0] cfg_chunk_size_mb
);
  import pcios_pkg::*;

  localparam int IdxW = $clog2(NUM_CHUNKS);
  localparam int QW = LenW + 2 + IdxW;

  logic [CfgW-1:0] size_r;
  logic            q_push, q_full, q_pop, q_empty;
  logic [LenW-1:0] f_len;
  logic            f_wr, f_oor;
  logic [IdxW-1:0] f_idx;
  logic [QW-1:0]   q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= CfgW'(1);
    else if (cfg_we) size_r <= cfg_chunk_size_mb;
  end

  pcios_front #(.NUM_CHUNKS(NUM_CHUNKS), .IDX_W(IdxW)) u_front (
    .clk, .rst_n, .start, .busy, .in_data, .size_mb(size_r),
    .q_push, .q_full, .q_len(f_len), .q_wr(f_wr), .q_oor(f_oor), .q_idx(f_idx)
  );

  pcios_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata({f_len, f_wr, f_oor, f_idx}),
    .full(q_full), .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  pcios_back #(.NUM_CHUNKS(NUM_CHUNKS), .IDX_W(IdxW)) u_back (
    .clk, .rst_n, .q_empty, .q_pop,
    .q_len(q_rdata[QW-1 -: LenW]), .q_wr(q_rdata[IdxW+1]),
    .q_oor(q_rdata[IdxW]), .q_idx(q_rdata[IdxW-1:0]),
    .out_valid, .out_data
  );
endmodule
`default_nettype wire

FILE: sim/per_chunk_io_statistics_chk.sv
`default_nettype none
module per_chunk_io_statistics_chk (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire pcios_pkg::in_beat_t        in_data,
  input  wire logic                       out_valid,
  input  wire pcios_pkg::out_beat_t       out_data,
  input  wire logic                       cfg_we,
  input  wire logic [pcios_pkg::CfgW-1:0] cfg_chunk_size_mb,
  output int                              fail_count,
  output int                              pending,
  output int                              oor_seen,
  output int                              first_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcios_pkg::*;

  localparam int Chunks = NumChunksDef;

  logic [CfgW-1:0]   size_mb;
  logic [CntW-1:0]   req_total;
  logic [CntW-1:0]   chunk_reqs [Chunks];
  bit                touched    [Chunks];
  logic [WinW-1:0]   touched_total;
  out_beat_t         awaited [$];

  assign pending = awaited.size();

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic out_beat_t tally(input in_beat_t req);
    out_beat_t      res;
    logic [63:0]    span;
    logic [63:0]    idx;
    res  = '0;
    span = 64'((size_mb == 0) ? 1 : size_mb) << SecPerMbLog2;
    idx  = 64'(req.start_sector) / span;
    if (req_total != '1) req_total++;
    if (idx >= Chunks) begin
      res.out_of_range = 1'b1;
      oor_seen++;
    end else begin
      if (chunk_reqs[idx] != '1) chunk_reqs[idx]++;
      if (!touched[idx]) begin
        res.first_in_window = 1'b1;
        first_seen++;
        if (touched_total != '1) touched_total++;
      end
      touched[idx]       = 1'b1;
      res.chunk_index    = idx[IdxOutW-1:0];
      res.chunk_requests = chunk_reqs[idx];
    end
    res.chunks_in_window = touched_total;
    res.total_requests   = req_total;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    oor_seen   = 0;
    first_seen = 0;
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      size_mb       <= 1;
      req_total      = '0;
      touched_total  = '0;
      for (int i = 0; i < Chunks; i++) begin
        chunk_reqs[i] = '0;
        touched[i]    = 1'b0;
      end
      awaited.delete();
    end else begin
      if (cfg_we) size_mb <= cfg_chunk_size_mb;
      if (start && !busy) awaited.push_back(tally(in_data));
      if (out_valid) begin
        if (awaited.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (out_data.chunk_index !== want.chunk_index)
            report("chunk_index", out_data.chunk_index, want.chunk_index);
          if (out_data.out_of_range !== want.out_of_range)
            report("out_of_range", out_data.out_of_range, want.out_of_range);
          if (out_data.first_in_window !== want.first_in_window)
            report("first_in_window", out_data.first_in_window, want.first_in_window);
          if (out_data.chunks_in_window !== want.chunks_in_window)
            report("chunks_in_window", out_data.chunks_in_window, want.chunks_in_window);
          if (out_data.total_requests !== want.total_requests)
            report("total_requests", out_data.total_requests, want.total_requests);
          if (out_data.chunk_requests !== want.chunk_requests)
            report("chunk_requests", out_data.chunk_requests, want.chunk_requests);
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sim/per_chunk_io_statistics_tb.sv
`default_nettype none
module per_chunk_io_statistics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcios_pkg::*;

  localparam int StallLimit = 20000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_beat_t          in_data;
  logic              out_valid;
  out_beat_t         out_data;
  logic              cfg_we;
  logic [CfgW-1:0]   cfg_chunk_size_mb;
  logic [CfgW-1:0]   cur_size;
  int                fail_count;
  int                pending;
  int                oor_seen;
  int                first_seen;
  int                sent;
  int                sizes_used;
  int                quiet;
  bit                no_idle;

  per_chunk_io_statistics uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_chunk_size_mb(cfg_chunk_size_mb)
  );

  per_chunk_io_statistics_chk chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_chunk_size_mb(cfg_chunk_size_mb), .fail_count(fail_count),
    .pending(pending), .oor_seen(oor_seen), .first_seen(first_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input in_beat_t req);
    bit taken;
    if (!no_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [CfgW-1:0] mb);
    drain();
    cfg_we            <= 1'b1;
    cfg_chunk_size_mb <= mb;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_size  = mb;
    sizes_used++;
  endtask

  function automatic in_beat_t at_chunk(input longint unsigned idx,
                                        input longint unsigned off,
                                        input logic [LenW-1:0] len, input bit wr);
    in_beat_t r;
    longint unsigned span;
    span             = longint'((cur_size == 0) ? 1 : cur_size) << SecPerMbLog2;
    r.start_sector   = LbaW'(idx * span + (off % span));
    r.length_sectors = len;
    r.is_write       = wr;
    return r;
  endfunction

  function automatic in_beat_t pick_request;
    in_beat_t        r;
    logic [LenW-1:0] len;
    int              mode;
    mode = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = '1;
      default: len = LenW'($urandom);
    endcase
    if (mode < 45)
      r = at_chunk($urandom_range(0, 15), $urandom, len, 1'($urandom_range(0, 1)));
    else if (mode < 70)
      r = at_chunk($urandom_range(0, NumChunksDef - 1), $urandom, len,
                   1'($urandom_range(0, 1)));
    else if (mode < 82)
      r = at_chunk($urandom_range(NumChunksDef - 2, NumChunksDef + 1),
                   $urandom_range(0, 1) ? 0 : 64'hFFFF_FFFF_FFFF, len,
                   1'($urandom_range(0, 1)));
    else begin
      r.start_sector   = {16'($urandom), 32'($urandom)};
      r.length_sectors = len;
      r.is_write       = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send(pick_request());
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_data           = '0;
    cfg_we            = 1'b0;
    cfg_chunk_size_mb = '0;
    cur_size          = 1;
    sent              = 0;
    sizes_used        = 1;
    quiet             = 0;
    no_idle           = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(at_chunk(0, 0, '0, 1'b0));
    send(at_chunk(0, 2047, '1, 1'b1));
    send(at_chunk(1, 0, 1, 1'b0));
    send(at_chunk(0, 5, 24'h80_0000, 1'b1));
    send(at_chunk(NumChunksDef - 1, 2047, 7, 1'b0));
    send(at_chunk(NumChunksDef, 0, 9, 1'b1));
    send('{start_sector: '1, length_sectors: '1, is_write: 1'b1});
    send(at_chunk(NumChunksDef - 1, 0, 3, 1'b1));
    drain();
    repeat (20) @(posedge clk);
    set_size(0);
    send(at_chunk(3, 100, 4, 1'b0));
    send(at_chunk(NumChunksDef, 0, 4, 1'b1));
    set_size(1024);
    send(at_chunk(NumChunksDef - 1, 64'hFFFF_FFFF, '1, 1'b0));
    send(at_chunk(NumChunksDef, 0, 1, 1'b1));
    send('{start_sector: '1, length_sectors: '0, is_write: 1'b0});
    set_size(2047);
    send(at_chunk(NumChunksDef - 1, 64'hFFFF_FFFF, 2, 1'b1));
    send(at_chunk(NumChunksDef, 0, 2, 1'b0));
    send('{start_sector: '0, length_sectors: '1, is_write: 1'b1});

    set_size(1);
    random_phase(250);
    set_size(0);
    random_phase(150);
    set_size(1024);
    no_idle = 1'b1;
    random_phase(250);
    no_idle = 1'b0;
    set_size(2047);
    random_phase(200);
    set_size(CfgW'($urandom_range(2, 1023)));
    random_phase(200);
    set_size(CfgW'($urandom_range(1025, 2046)));
    random_phase(150);
    set_size(1);
    random_phase(180);

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d requests over %0d chunk sizes", sent, sizes_used);
    $display("%0d out-of-range requests, %0d first touches of a chunk", oor_seen, first_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/pcios_pkg.sv
rtl/pcios_front.sv
rtl/pcios_queue.sv
rtl/pcios_back.sv
rtl/per_chunk_io_statistics.sv
sim/per_chunk_io_statistics_chk.sv
sim/per_chunk_io_statistics_tb.sv
